### rtl/rgb_sobel_edge_magnitude_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGB Sobel edge magnitude block
// Shared property forms; each use names its own label.
// ----------------------------------------------------------------------------
`ifndef RGB_SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH
`define RGB_SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RSEM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsem same-cycle check failed");

// next-cycle implication, checked outside reset
`define RSEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsem next-cycle check failed");

`endif

### rtl/rsem_pkg.sv
// ----------------------------------------------------------------------------
// rsem_pkg
// Types, kernels and helpers shared by the Sobel edge magnitude modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rsem_pkg;

  typedef logic [23:0] pix_t;

  // one 3x3 neighborhood, index row*3+col, out-of-frame taps already zero
  typedef struct packed {
    logic            last;
    logic [8:0][23:0] win;
  } job_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [7:0] SAT_MAX = 8'd255;

  localparam logic signed [2:0] KERN_X [9] = '{3'sd1, 3'sd0, -3'sd1,
                                               3'sd2, 3'sd0, -3'sd2,
                                               3'sd1, 3'sd0, -3'sd1};
  localparam logic signed [2:0] KERN_Y [9] = '{3'sd1, 3'sd2, 3'sd1,
                                               3'sd0, 3'sd0, 3'sd0,
                                               -3'sd1, -3'sd2, -3'sd1};

  // gradient of one channel over nine taps
  function automatic logic signed [10:0] grad(input logic [8:0][7:0] v,
                                              input logic use_y);
    logic signed [10:0] acc;
    logic signed [10:0] kv;
    acc = '0;
    for (int k = 0; k < 9; k++) begin
      kv  = use_y ? 11'(KERN_Y[k]) : 11'(KERN_X[k]);
      acc = acc + $signed({3'b000, v[k]}) * kv;
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

### rtl/rsem_if.sv
// ----------------------------------------------------------------------------
// rsem_in_if / rsem_out_if
// Valid/ready channels for pixel beats in and edge beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsem_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;

  modport source (output valid, req_type, pixel_red, pixel_green, pixel_blue,
                  input ready);
  modport sink   (input valid, req_type, pixel_red, pixel_green, pixel_blue,
                  output ready);
endinterface

interface rsem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       frame_last;

  modport source (output valid, edge_red, edge_green, edge_blue, frame_last,
                  input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, frame_last,
                  output ready);
endinterface

`default_nettype wire

### rtl/rgb_sobel_edge_magnitude_top.sv
// ----------------------------------------------------------------------------
// rgb_sobel_edge_magnitude_top
// Streaming 3x3 Sobel edge magnitude on RGB24 pixels, zero padded.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each channel gets min(255, floor(sqrt(gx^2+gy^2))).
// Output pixel k appears after input beat k+width+1, so send width+1 flush beats
// after a frame. The front reads the line store when it accepts an input beat, then
// writes it back before taking another. Per output pixel the back runs the gradient,
// square, eight root steps and the output beat; a two-entry queue between them
// lets the front keep taking beats while a result waits. Writing either register
// restarts the frame; line store contents are kept.
`default_nettype none

module rgb_sobel_edge_magnitude_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rsem_in_if.sink          in_if,
  rsem_out_if.source       out_if,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic {REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1} reg_idx_t;

  logic [11:0]       width_r;
  logic [12:0]       height_r;
  logic              cfg_wr;
  logic [WW-1:0]     width_eff;
  logic [HW-1:0]     height_eff;
  logic              push, pop;
  rsem_pkg::job_t    push_job, head;
  rsem_pkg::qstat_t  qstat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 13'd480;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_paddr[2]))
        REG_WIDTH:  width_r  <= cfg_pwdata[11:0];
        REG_HEIGHT: height_r <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[2]))
      REG_WIDTH:  cfg_prdata = {20'd0, width_r};
      REG_HEIGHT: cfg_prdata = {19'd0, height_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // clamp to the supported frame size
  always_comb begin
    if (width_r == '0)                         width_eff = WW'(1);
    else if (32'(width_r) > 32'(MAX_WIDTH))    width_eff = WW'(MAX_WIDTH);
    else                                       width_eff = WW'(width_r);
    if (height_r == '0)                        height_eff = HW'(1);
    else if (32'(height_r) > 32'(MAX_HEIGHT))  height_eff = HW'(MAX_HEIGHT);
    else                                       height_eff = HW'(height_r);
  end

  rsem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WW         (WW),
    .HW         (HW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .in_ch      (in_if),
    .qstat      (qstat),
    .push       (push),
    .push_job   (push_job)
  );

  rsem_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  rsem_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_if)
  );

endmodule

`default_nettype wire

### rtl/rsem_front.sv
// ----------------------------------------------------------------------------
// rsem_front
// Accepts pixel beats, runs the line stores and window, queues neighborhoods.
// ----------------------------------------------------------------------------
`default_nettype none

module rsem_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int WW         = 12,
  parameter int HW         = 13
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           restart,
  input  wire logic [WW-1:0]  width_eff,
  input  wire logic [HW-1:0]  height_eff,
  rsem_in_if.sink             in_ch,
  input  rsem_pkg::qstat_t    qstat,
  output logic                push,
  output rsem_pkg::job_t      push_job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  typedef enum logic {F_IDLE, F_UPD} fstate_t;

  fstate_t              state_r;
  logic [CW-1:0]        col_r;
  logic [1:0]           irow_r;
  logic [CW-1:0]        ocol_r;
  logic [RW-1:0]        orow_r;
  logic [8:0][23:0]     win_r;
  rsem_pkg::pix_t       pix_r;
  logic [47:0]          line_rd_r;
  logic [47:0]          line_mem [MAX_WIDTH];

  logic [8:0][23:0]     win_nxt;
  logic                 accept;
  logic                 prime;
  logic                 col_wrap, ocol_end, orow_end, last;
  logic [1:0]           irow_inc;

  assign in_ch.ready = (state_r == F_IDLE) && !qstat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // window after shifting in the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = line_rd_r[47:24];
    win_nxt[5] = line_rd_r[23:0];
    win_nxt[8] = pix_r;
  end

  // position decode
  assign prime    = (irow_r == 2'd0) || ((irow_r == 2'd1) && (col_r == '0));
  assign col_wrap = (32'(col_r) + 32'd1) >= 32'(width_eff);
  assign ocol_end = (32'(ocol_r) + 32'd1) >= 32'(width_eff);
  assign orow_end = (32'(orow_r) + 32'd1) >= 32'(height_eff);
  assign last     = ocol_end && orow_end;
  assign irow_inc = (irow_r == 2'd2) ? 2'd2 : irow_r + 2'd1;

  // masked neighborhood toward the queue
  always_comb begin
    push_job.last = last;
    for (int k = 0; k < 9; k++) begin
      if (((k / 3) == 0 && orow_r == '0) || ((k / 3) == 2 && orow_end) ||
          ((k % 3) == 0 && ocol_r == '0) || ((k % 3) == 2 && ocol_end)) begin
        push_job.win[k] = '0;
      end else begin
        push_job.win[k] = win_nxt[k];
      end
    end
  end

  assign push = (state_r == F_UPD) && !prime && !restart;

  // line store: read on accept, write back on update
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd_r <= line_mem[col_r];
    end
    if (state_r == F_UPD) begin
      line_mem[col_r] <= {line_rd_r[23:0], pix_r};
    end
  end

  // sequencer, counters and window
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      irow_r  <= '0;
      ocol_r  <= '0;
      orow_r  <= '0;
      win_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            pix_r   <= in_ch.req_type ? 24'd0 :
                       {in_ch.pixel_red, in_ch.pixel_green, in_ch.pixel_blue};
            state_r <= F_UPD;
          end
        end
        F_UPD: begin
          win_r   <= win_nxt;
          state_r <= F_IDLE;
          if (!prime && last) begin
            col_r  <= '0;
            irow_r <= '0;
            ocol_r <= '0;
            orow_r <= '0;
          end else begin
            col_r <= col_wrap ? '0 : col_r + CW'(1);
            if (col_wrap) begin
              irow_r <= irow_inc;
            end
            if (!prime) begin
              ocol_r <= ocol_end ? '0 : ocol_r + CW'(1);
              if (ocol_end) begin
                orow_r <= orow_r + RW'(1);
              end
            end
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/rsem_queue.sv
// ----------------------------------------------------------------------------
// rsem_queue
// Two-entry queue of neighborhoods between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_sobel_edge_magnitude_top_defines.svh"

module rsem_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  rsem_pkg::job_t    push_job,
  input  wire logic         pop,
  output rsem_pkg::job_t    head,
  output rsem_pkg::qstat_t  qstat
);

  rsem_pkg::job_t                  ent_r [rsem_pkg::QUEUE_DEPTH];
  logic [rsem_pkg::QPTR_W-1:0]     wr_r, rd_r;
  logic [rsem_pkg::QCNT_W-1:0]     cnt_r;

  assign qstat.full  = (cnt_r == rsem_pkg::QCNT_W'(rsem_pkg::QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head        = ent_r[rd_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + rsem_pkg::QCNT_W'(push) - rsem_pkg::QCNT_W'(pop);
    end
  end

  `RSEM_ASSERT_NOW(a_no_overflow, push && !pop, !qstat.full)
  `RSEM_ASSERT_NOW(a_no_underflow, pop, !qstat.empty)
  `RSEM_ASSERT_NEXT(a_count_tracks, push && !pop && !qstat.full, !qstat.empty)

endmodule

`default_nettype wire

### rtl/rsem_back.sv
// ----------------------------------------------------------------------------
// rsem_back
// Gradients, squared magnitude and bitwise square root for three channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rsem_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  rsem_pkg::job_t    head,
  input  rsem_pkg::qstat_t  qstat,
  output logic              pop,
  rsem_out_if.source        out_ch
);

  typedef enum logic [1:0] {B_IDLE, B_SQR, B_ROOT, B_OUT} bstate_t;

  bstate_t                   state_r;
  logic signed [10:0]        gx_r [3];
  logic signed [10:0]        gy_r [3];
  logic [20:0]               mag_r [3];
  logic [7:0]                root_r [3];
  logic [7:0]                bit_r;
  logic                      last_r;

  logic [2:0][8:0][7:0]      taps;
  logic [2:0][7:0]           edge_v;
  logic [2:0][7:0]           trial;

  // split the neighborhood per channel, red first
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        taps[ch][k] = head.win[k][23-8*ch -: 8];
      end
      trial[ch]  = root_r[ch] | bit_r;
      edge_v[ch] = (mag_r[ch][20:16] != '0) ? rsem_pkg::SAT_MAX : root_r[ch];
    end
  end

  assign pop                = (state_r == B_IDLE) && !qstat.empty;
  assign out_ch.valid       = (state_r == B_OUT);
  assign out_ch.edge_red    = edge_v[0];
  assign out_ch.edge_green  = edge_v[1];
  assign out_ch.edge_blue   = edge_v[2];
  assign out_ch.frame_last  = last_r;

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (pop) begin
            for (int ch = 0; ch < 3; ch++) begin
              gx_r[ch] <= rsem_pkg::grad(taps[ch], 1'b0);
              gy_r[ch] <= rsem_pkg::grad(taps[ch], 1'b1);
            end
            last_r  <= head.last;
            state_r <= B_SQR;
          end
        end
        B_SQR: begin
          for (int ch = 0; ch < 3; ch++) begin
            mag_r[ch]  <= 21'(22'(gx_r[ch]) * 22'(gx_r[ch]))
                        + 21'(22'(gy_r[ch]) * 22'(gy_r[ch]));
            root_r[ch] <= '0;
          end
          bit_r   <= 8'h80;
          state_r <= B_ROOT;
        end
        B_ROOT: begin
          // one result bit per cycle, msb first
          for (int ch = 0; ch < 3; ch++) begin
            if (21'(16'(trial[ch]) * 16'(trial[ch])) <= mag_r[ch]) begin
              root_r[ch] <= trial[ch];
            end
          end
          bit_r <= bit_r >> 1;
          if (bit_r[0]) begin
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_ch.ready) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: RGB Sobel edge magnitude testbench
// Drives raster frames of RGB beats plus their drain beats through the block,
// predicts every edge beat from a model of the window and line stores, and
// checks the results in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------

// Register byte addresses on the configuration port
localparam logic [2:0] ADDR_FRAME_WIDTH  = 3'd0;
localparam logic [2:0] ADDR_FRAME_HEIGHT = 3'd4;
localparam int         LINE_DEPTH        = 2048;
localparam int         LINES_MAX         = 4096;
localparam int         DRAIN_CYCLES      = 60;
localparam int         STALL_LIMIT       = 20000;
localparam int         BROKEN_MAX        = 160;

typedef enum logic {BEAT_PIXEL = 1'b0, BEAT_FLUSH = 1'b1} beat_kind_e;

// Predicts edge beats and checks them in order
class edge_scoreboard;
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } edge_beat_t;

  edge_beat_t  edge_q[$];
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [23:0] upper_line[LINE_DEPTH];
  logic [23:0] middle_line[LINE_DEPTH];
  logic [23:0] win[3][3];
  int unsigned in_col, in_row, out_col, out_row;
  int          errors;
  int          checked;
  int          frames_done;

  function new();
    width_reg  = 12'd640;
    height_reg = 13'd480;
    foreach (upper_line[i]) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    errors = 0;
    checked = 0;
    frames_done = 0;
    restart();
  endfunction

  function void restart();
    foreach (win[r, c]) win[r][c] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > LINES_MAX) return LINES_MAX;
    return height_reg;
  endfunction

  function void note_write(logic [2:0] addr, logic [31:0] data);
    if (addr == ADDR_FRAME_WIDTH) width_reg = data[11:0];
    else if (addr == ADDR_FRAME_HEIGHT) height_reg = data[12:0];
    else return;
    restart();
  endfunction

  // floor of the square root, clipped to 255
  function logic [7:0] root_sat(int unsigned v);
    int unsigned root, t;
    root = 0;
    if (v >= 65536) return 8'd255;
    for (int bitv = 128; bitv != 0; bitv = bitv >> 1) begin
      t = root | bitv;
      if (t * t <= v) root = t;
    end
    return root[7:0];
  endfunction

  function void note_beat(beat_kind_e kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, c, ox, oy;
    longint unsigned pos;
    logic [23:0] pix;
    logic [23:0] tap[3][3];
    int v[3][3];
    int gx, gy;
    logic [7:0] mag[3];
    edge_beat_t e;
    w = eff_width();
    h = eff_height();
    c = in_col % w;
    pix = (kind == BEAT_PIXEL) ? {r, g, b} : 24'd0;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = middle_line[c];
    win[2][2] = pix;
    upper_line[c] = middle_line[c];
    middle_line[c] = pix;
    pos = longint'(in_row) * w + c;
    if (pos < w + 1) begin
      in_col = c + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      return;
    end
    ox = out_col;
    oy = out_row;
    // zero the taps that fall outside the frame
    foreach (tap[i, j]) begin
      tap[i][j] = win[i][j];
      if ((i == 0 && oy == 0) || (i == 2 && oy + 1 >= h) ||
          (j == 0 && ox == 0) || (j == 2 && ox + 1 >= w)) tap[i][j] = '0;
    end
    for (int ch = 0; ch < 3; ch++) begin
      foreach (v[i, j]) v[i][j] = (tap[i][j] >> (16 - 8 * ch)) & 8'hFF;
      gx = v[0][0] - v[0][2] + 2 * v[1][0] - 2 * v[1][2] + v[2][0] - v[2][2];
      gy = v[0][0] + 2 * v[0][1] + v[0][2] - v[2][0] - 2 * v[2][1] - v[2][2];
      mag[ch] = root_sat(gx * gx + gy * gy);
    end
    e.red = mag[0];
    e.green = mag[1];
    e.blue = mag[2];
    e.last = (ox + 1 >= w) && (oy + 1 >= h);
    edge_q.push_back(e);
    if (e.last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end else begin
      out_col = ox + 1;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      in_col = c + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
  endfunction

  function void check_edge(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    edge_beat_t e;
    if (edge_q.size() == 0) begin
      $error("unexpected edge beat: red %0d green %0d blue %0d last %0d", r, g, b, last);
      errors++;
      return;
    end
    e = edge_q.pop_front();
    checked++;
    if (last === 1'b1) frames_done++;
    if (r !== e.red) begin
      $error("edge_red: expected %0d, got %0d", e.red, r);
      errors++;
    end
    if (g !== e.green) begin
      $error("edge_green: expected %0d, got %0d", e.green, g);
      errors++;
    end
    if (b !== e.blue) begin
      $error("edge_blue: expected %0d, got %0d", e.blue, b);
      errors++;
    end
    if (last !== e.last) begin
      $error("frame_last: expected %0d, got %0d", e.last, last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int idle_pct;
  int stall_pct;
  int stall_cycles;
  int beats_sent;
  int cfg_writes;

  edge_scoreboard sb;

  rsem_in_if  in_ch ();
  rsem_out_if out_ch ();

  rgb_sobel_edge_magnitude_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver stalls at the current rate
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  // watch accepted beats and register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_beat(beat_kind_e'(in_ch.req_type), in_ch.pixel_red,
                     in_ch.pixel_green, in_ch.pixel_blue);
      if (out_ch.valid && out_ch.ready)
        sb.check_edge(out_ch.edge_red, out_ch.edge_green, out_ch.edge_blue,
                      out_ch.frame_last);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        sb.note_write(cfg_paddr, cfg_pwdata);
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic set_phase(int p);
    case (p)
      0: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct = 76;
        stall_pct = 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct = 76;
      end
      default: begin
        idle_pct = 24;
        stall_pct = 24;
      end
    endcase
  endtask

  // one input beat; called at a falling edge, returns at a falling edge
  task automatic send_beat(beat_kind_e kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.req_type = kind;
    in_ch.pixel_red = r;
    in_ch.pixel_green = g;
    in_ch.pixel_blue = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_level();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
    return $urandom_range(255);
  endfunction

  task automatic send_random(beat_kind_e kind);
    send_beat(kind, rand_level(), rand_level(), rand_level());
  endtask

  // stop sending, then let every result and the pipeline drain
  task automatic settle();
    in_ch.valid = 1'b0;
    while (sb.edge_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = addr;
    cfg_pwdata = data;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_writes++;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // program the size, then a frame with its drain beats; broken frames stop early,
  // after at most BROKEN_MAX beats
  task automatic run_frame(logic [31:0] wval, logic [31:0] hval, bit broken, int noise_pct);
    int unsigned w, h, n, total;
    settle();
    cfg_write(ADDR_FRAME_WIDTH, wval);
    cfg_write(ADDR_FRAME_HEIGHT, hval);
    w = sb.eff_width();
    h = sb.eff_height();
    total = w * h + w + 1;
    n = broken ? $urandom_range(1, (total - 1 > BROKEN_MAX) ? BROKEN_MAX : total - 1)
               : total;
    for (int unsigned i = 0; i < n; i++) begin
      if (i < w * h)
        send_random(($urandom_range(99) < noise_pct) ? BEAT_FLUSH : BEAT_PIXEL);
      else
        send_random(($urandom_range(99) < noise_pct) ? BEAT_PIXEL : BEAT_FLUSH);
    end
  endtask

  initial begin
    logic [31:0] wv, hv;
    int budget;
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    stall_cycles = 0;
    beats_sent = 0;
    cfg_writes = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = BEAT_PIXEL;
    in_ch.pixel_red = '0;
    in_ch.pixel_green = '0;
    in_ch.pixel_blue = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed: 3x3 checkerboard of extremes, then 4x2 with a black flush
    // inside the frame and pixel data in the first drain beat
    settle();
    cfg_write(ADDR_FRAME_WIDTH, 32'd3);
    cfg_write(ADDR_FRAME_HEIGHT, 32'd3);
    for (int i = 0; i < 9; i++) begin
      if (i % 2 == 0) send_beat(BEAT_PIXEL, 8'd255, 8'd0, 8'd255);
      else send_beat(BEAT_PIXEL, 8'd0, 8'd255, 8'd0);
    end
    for (int i = 0; i < 4; i++) send_beat(BEAT_FLUSH, 8'd255, 8'd255, 8'd255);
    settle();
    cfg_write(ADDR_FRAME_WIDTH, 32'd4);
    cfg_write(ADDR_FRAME_HEIGHT, 32'd2);
    for (int i = 0; i < 8; i++) begin
      if (i == 5) send_beat(BEAT_FLUSH, 8'd255, 8'd255, 8'd255);
      else send_beat(BEAT_PIXEL, 8'd255, 8'd255, 8'd255);
    end
    send_beat(BEAT_PIXEL, 8'd255, 8'd128, 8'd1);
    for (int i = 0; i < 4; i++) send_beat(BEAT_FLUSH, 8'd0, 8'd0, 8'd0);

    // register extremes, unstalled: clamped and full-size widths and heights,
    // the large ones cut short
    set_phase(0);
    run_frame({20'hABCDE, 12'd2048}, 32'd1, 1'b1, 2);
    run_frame(32'd4095, 32'd1, 1'b1, 2);
    run_frame(32'd0, 32'd3, 1'b0, 2);
    run_frame(32'd2, 32'd0, 1'b0, 2);
    run_frame(32'd1, {19'h5A5A5, 13'd4096}, 1'b1, 2);
    run_frame(32'd1, 32'd8191, 1'b1, 2);

    // random frames, mostly small and well formed, across the idling phases
    for (int p = 0; p < 4; p++) begin
      set_phase(p);
      budget = beats_sent + 360;
      while (beats_sent < budget) begin
        wv = $urandom_range(1, 12);
        hv = $urandom_range(1, 8);
        if ($urandom_range(9) == 0) wv = $urandom_range(13, 40);
        if ($urandom_range(7) == 0) wv = wv | ($urandom() << 12);
        if ($urandom_range(7) == 0) hv = hv | ($urandom() << 13);
        run_frame(wv, hv, $urandom_range(9) == 0, ($urandom_range(4) == 0) ? 10 : 0);
      end
    end

    settle();
    if (sb.edge_q.size() != 0) begin
      $error("%0d edge beats never arrived", sb.edge_q.size());
      sb.errors++;
    end
    $display("Sent %0d pixel/drain beats with %0d register writes under four idling mixes,",
             beats_sent, cfg_writes);
    $display("checked %0d edge beats over %0d completed frames.", sb.checked, sb.frames_done);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### rgb_sobel_edge_magnitude_top.f
+incdir+rtl
rtl/rsem_pkg.sv
rtl/rsem_if.sv
rtl/rsem_front.sv
rtl/rsem_queue.sv
rtl/rsem_back.sv
rtl/rgb_sobel_edge_magnitude_top.sv
bench/tb_top.sv
